@@ rtl/hashed_timer_wheel_defines.svh @@
`ifndef HASHED_TIMER_WHEEL_DEFINES_SVH
`define HASHED_TIMER_WHEEL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/htw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;

	localparam int MAX_SLOTS_DEF  = 256;
	localparam int NUM_TIMERS_DEF = 32;
	localparam int ROUND_BITS_DEF = 32;

	localparam int CFG_W   = 10;
	localparam int DELAY_W = 20;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic CFG_SLOT_COUNT = 1'b0;
	localparam logic CFG_TICK_MS    = 1'b1;

	localparam logic [1:0] KIND_ADD_OK = 2'd0;
	localparam logic [1:0] KIND_FULL   = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [8:0] SLOT_COUNT_RST = 9'd256;
	localparam logic [9:0] TICK_MS_RST    = 10'd10;

	typedef struct packed {
		logic               command;
		logic [15:0]        timer_id;
		logic [DELAY_W-1:0] first_delay_ms;
		logic [DELAY_W-1:0] period_ms;
		logic               repeating;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] fired_id;
		logic [7:0]  slot_now;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_LINK,
		S_HEAD,
		S_WALK,
		S_POP,
		S_POP_W,
		S_RELOAD,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/htw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/htw_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module htw_div #(
	parameter int W = 21
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] quot,
	output logic      [W-1:0] rem
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [W-1:0]     quot_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quot_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (run_q) begin
			rem_q  <= ge ? diff[W-1:0] : trial[W-1:0];
			quot_q <= {quot_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

@@ rtl/hashed_timer_wheel.sv @@
// Add: two serial divisions, one bit a cycle, then a list insert unless the pool is full.
// Tick: walks the current slot's list, then re-arms each fired repeating timer as an add does.
// Results appear on the cycle after they are formed; each is shown for one cycle only.
// The receiver cannot stall; busy is low only when the block can take a new item.
// After reset a clearing pass empties all slot lists; busy stays high until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_timer_wheel_defines.svh"
module hashed_timer_wheel #(
	parameter int MAX_SLOTS  = htw_pkg::MAX_SLOTS_DEF,
	parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF,
	parameter int ROUND_BITS = htw_pkg::ROUND_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire htw_pkg::in_item_t     item,
	output logic                       strobe,
	output htw_pkg::result_t           result,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [htw_pkg::CFG_W-1:0] cfg_data
);

	import htw_pkg::*;

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int IDX_W  = $clog2(NUM_TIMERS);
	localparam int SP_W   = $clog2(NUM_TIMERS + 1);
	localparam int DIV_W  = ((SLOT_W > DELAY_W) ? SLOT_W : DELAY_W) + 1;
	localparam int NSL_W  = $clog2(MAX_SLOTS + 1);
	localparam int SC_W   = (NSL_W > 9) ? NSL_W : 9;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} head_t;

	typedef struct packed {
		logic [IDX_W-1:0]      nxt;
		logic                  nv;
		logic [15:0]           tag;
		logic [ROUND_BITS-1:0] rnd;
		logic [DELAY_W-1:0]    period;
		logic                  rpt;
	} entry_t;

	state_t state_q, state_d;

	logic [SLOT_W-1:0]     cs_q;
	logic [ROUND_BITS-1:0] rot_q;
	logic [NUM_TIMERS-1:0] free_q;
	logic [8:0]            slot_count_q;
	logic [9:0]            tick_ms_q;
	logic [SLOT_W-1:0]     clr_q;
	logic [SP_W-1:0]       sp_q;
	logic [SP_W-1:0]       steps_q;
	logic                  have_prev_q;
	logic                  rearm_q;
	logic                  strobe_q;
	result_t               result_q;

	logic [15:0]           tag_q;
	logic [DELAY_W-1:0]    period_q;
	logic                  rpt_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [ROUND_BITS-1:0] round_q;
	logic [IDX_W-1:0]      r_q;
	entry_t                ent_q;
	logic [IDX_W-1:0]      prev_q;
	entry_t                prev_ent_q;
	logic [IDX_W-1:0]      cur_e_q;

	logic                  sr_we;
	logic [SLOT_W-1:0]     sr_waddr, sr_raddr;
	head_t                 sr_wdata, sr_rd;
	logic                  er_we;
	logic [IDX_W-1:0]      er_waddr, er_raddr;
	entry_t                er_wdata, er_rd;
	logic                  st_we;
	logic [IDX_W-1:0]      st_waddr, st_raddr, st_wdata, st_rd;

	logic                  div_start, div_done;
	logic [DIV_W-1:0]      div_a, div_b, div_quot, div_rem;

	logic                  emit;
	result_t               emit_res;

	logic [SC_W-1:0]       sc_ext;
	logic [DIV_W-1:0]      n_eff, tick_eff;
	logic [IDX_W-1:0]      free_idx;
	logic                  free_any;
	logic                  match, walk_more;
	logic [SLOT_W:0]       cs_inc;
	logic [ROUND_BITS-1:0] round_calc;
	logic                  accept;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		sc_ext = SC_W'(slot_count_q);
		if (sc_ext < SC_W'(2)) begin
			n_eff = DIV_W'(2);
		end else if (sc_ext > SC_W'(MAX_SLOTS)) begin
			n_eff = DIV_W'(MAX_SLOTS);
		end else begin
			n_eff = DIV_W'(sc_ext);
		end
		tick_eff = (tick_ms_q == '0) ? DIV_W'(1) : DIV_W'(tick_ms_q);
	end

	always_comb begin
		free_idx = '0;
		for (int e = NUM_TIMERS - 1; e >= 0; e--) begin
			if (free_q[e]) begin
				free_idx = IDX_W'(e);
			end
		end
		free_any = |free_q;
	end

	assign match      = (er_rd.rnd == rot_q);
	assign walk_more  = er_rd.nv && ((steps_q + SP_W'(1)) < SP_W'(NUM_TIMERS));
	assign cs_inc     = {1'b0, cs_q} + (SLOT_W + 1)'(1);
	assign round_calc = rot_q + ROUND_BITS'(div_quot);

	htw_ram #(.WIDTH($bits(head_t)), .DEPTH(MAX_SLOTS)) u_slot_ram (
		.clk(clk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata),
		.raddr(sr_raddr), .rdata(sr_rd)
	);

	htw_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_TIMERS)) u_entry_ram (
		.clk(clk), .we(er_we), .waddr(er_waddr), .wdata(er_wdata),
		.raddr(er_raddr), .rdata(er_rd)
	);

	htw_ram #(.WIDTH(IDX_W), .DEPTH(NUM_TIMERS)) u_rearm_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rd)
	);

	htw_div #(.W(DIV_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == SLOT_W'(MAX_SLOTS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					state_d = (item.command == CMD_ADD) ? S_DIV1 : S_HEAD;
				end
			end
			S_DIV1: if (div_done) state_d = S_DIV2;
			S_DIV2: begin
				if (div_done) begin
					state_d = (!rearm_q && !free_any) ? S_IDLE : S_LINK;
				end
			end
			S_LINK:   state_d = rearm_q ? S_POP : S_IDLE;
			S_HEAD:   state_d = sr_rd.valid ? S_WALK : S_POP;
			S_WALK:   state_d = walk_more ? S_WALK : S_POP;
			S_POP:    state_d = (sp_q == '0) ? S_DONE : S_POP_W;
			S_POP_W:  state_d = S_RELOAD;
			S_RELOAD: state_d = S_DIV1;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		sr_we     = 1'b0;
		sr_waddr  = cs_q;
		sr_wdata  = '0;
		sr_raddr  = cs_q;
		er_we     = 1'b0;
		er_waddr  = prev_q;
		er_wdata  = prev_ent_q;
		er_raddr  = er_rd.nxt;
		st_we     = 1'b0;
		st_waddr  = sp_q[IDX_W-1:0];
		st_wdata  = cur_e_q;
		st_raddr  = IDX_W'(sp_q - SP_W'(1));
		div_start = 1'b0;
		div_a     = DIV_W'(item.first_delay_ms);
		div_b     = tick_eff;
		emit      = 1'b0;
		emit_res  = '0;
		case (state_q)
			S_CLEAR: begin
				sr_we    = 1'b1;
				sr_waddr = clr_q;
			end
			S_IDLE: begin
				div_start = accept && (item.command == CMD_ADD);
			end
			S_DIV1: begin
				div_start = div_done;
				div_a     = DIV_W'(cs_q) + div_quot;
				div_b     = n_eff;
			end
			S_DIV2: begin
				sr_raddr = div_rem[SLOT_W-1:0];
				if (div_done && !rearm_q && !free_any) begin
					emit     = 1'b1;
					emit_res = '{kind: KIND_FULL, fired_id: 16'd0,
						slot_now: 8'(div_rem[SLOT_W-1:0]), last: 1'b1};
				end
			end
			S_LINK: begin
				er_we    = 1'b1;
				er_waddr = rearm_q ? r_q : free_idx;
				er_wdata = rearm_q ? ent_q : entry_t'{nxt: '0, nv: 1'b0, tag: tag_q,
					rnd: '0, period: period_q, rpt: rpt_q};
				er_wdata.nxt = sr_rd.idx;
				er_wdata.nv  = sr_rd.valid;
				er_wdata.rnd = round_q;
				sr_we    = 1'b1;
				sr_waddr = slot_q;
				sr_wdata = '{valid: 1'b1, idx: er_waddr};
				if (!rearm_q) begin
					emit     = 1'b1;
					emit_res = '{kind: KIND_ADD_OK, fired_id: 16'd0,
						slot_now: 8'(slot_q), last: 1'b1};
				end
			end
			S_HEAD: begin
				er_raddr = sr_rd.idx;
			end
			S_WALK: begin
				if (match) begin
					emit     = 1'b1;
					emit_res = '{kind: KIND_FIRED, fired_id: er_rd.tag,
						slot_now: 8'(cs_q), last: 1'b0};
					// unlink: patch the previous survivor or the slot head
					if (have_prev_q) begin
						er_we        = 1'b1;
						er_wdata.nxt = er_rd.nxt;
						er_wdata.nv  = er_rd.nv;
					end else begin
						sr_we    = 1'b1;
						sr_wdata = '{valid: er_rd.nv, idx: er_rd.nxt};
					end
					st_we = er_rd.rpt;
				end
			end
			S_POP_W: begin
				er_raddr = st_rd;
			end
			S_RELOAD: begin
				div_start = 1'b1;
				div_a     = DIV_W'(er_rd.period);
			end
			S_DONE: begin
				emit     = 1'b1;
				emit_res = '{kind: KIND_DONE, fired_id: 16'd0,
					slot_now: 8'(cs_q), last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cs_q         <= '0;
			rot_q        <= '0;
			free_q       <= '1;
			slot_count_q <= SLOT_COUNT_RST;
			tick_ms_q    <= TICK_MS_RST;
			clr_q        <= '0;
			sp_q         <= '0;
			steps_q      <= '0;
			have_prev_q  <= 1'b0;
			rearm_q      <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SLOT_COUNT: slot_count_q <= cfg_data[8:0];
					CFG_TICK_MS:    tick_ms_q    <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: clr_q <= clr_q + SLOT_W'(1);
				S_IDLE: begin
					rearm_q     <= 1'b0;
					have_prev_q <= 1'b0;
					steps_q     <= '0;
				end
				S_LINK: begin
					if (!rearm_q) begin
						free_q[free_idx] <= 1'b0;
					end
				end
				S_WALK: begin
					steps_q <= steps_q + SP_W'(1);
					if (match) begin
						if (er_rd.rpt) begin
							sp_q <= sp_q + SP_W'(1);
						end else begin
							free_q[cur_e_q] <= 1'b1;
						end
					end else begin
						have_prev_q <= 1'b1;
					end
				end
				S_POP: if (sp_q != '0) sp_q <= sp_q - SP_W'(1);
				S_RELOAD: rearm_q <= 1'b1;
				S_DONE: begin
					// advance, wrap and bump rotation
					if (DIV_W'(cs_inc) >= n_eff) begin
						cs_q  <= '0;
						rot_q <= rot_q + ROUND_BITS'(1);
					end else begin
						cs_q <= cs_inc[SLOT_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= emit_res;
		end
		if (accept) begin
			tag_q    <= item.timer_id;
			period_q <= item.period_ms;
			rpt_q    <= item.repeating;
		end
		if (state_q == S_DIV2 && div_done) begin
			slot_q  <= div_rem[SLOT_W-1:0];
			round_q <= round_calc;
		end
		if (state_q == S_HEAD) begin
			cur_e_q <= sr_rd.idx;
		end
		if (state_q == S_WALK) begin
			cur_e_q <= er_rd.nxt;
			if (match) begin
				prev_ent_q.nxt <= er_rd.nxt;
				prev_ent_q.nv  <= er_rd.nv;
			end else begin
				prev_q     <= cur_e_q;
				prev_ent_q <= er_rd;
			end
		end
		if (state_q == S_POP_W) begin
			r_q <= st_rd;
		end
		if (state_q == S_RELOAD) begin
			ent_q <= er_rd;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`HTW_ASSERT_NOW(a_fired_not_last, strobe && result.kind == KIND_FIRED, !result.last, "fired beat marked last")
	`HTW_ASSERT_NEXT(a_busy_after_start, accept, busy, "block idle after taking an item")
	`HTW_ASSERT_NOW(a_rearm_depth, 1'b1, sp_q <= SP_W'(NUM_TIMERS), "re-arm stack overflow")
	`HTW_ASSERT_NEXT(a_done_ends_tick, state_q == S_DONE, strobe && result.last && result.kind == KIND_DONE, "tick did not end with tick done")

endmodule
`default_nettype wire

@@ tb/tb_hashed_timer_wheel.sv @@
`timescale 1ns / 1ps
module tb_hashed_timer_wheel;
	import htw_pkg::*;

	localparam int SLOTS = 256;
	localparam int TIMERS = 32;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 3000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic strobe;
	result_t result;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	hashed_timer_wheel i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// wheel model
	bit [7:0] head_idx [SLOTS];
	bit head_ok [SLOTS];
	bit [4:0] link_idx [TIMERS];
	bit link_ok [TIMERS];
	bit [15:0] ent_tag [TIMERS];
	bit [31:0] ent_round [TIMERS];
	bit [19:0] ent_period [TIMERS];
	bit ent_repeat [TIMERS];
	bit [TIMERS-1:0] free_set;
	int cur_slot;
	bit [31:0] rot_count;
	bit [8:0] slot_count_reg;
	bit [9:0] tick_ms_reg;

	result_t pending_q[$];
	int errors;
	int cycles;
	bit no_gaps;

	function automatic int wheel_size();
		if (slot_count_reg < 2) return 2;
		if (slot_count_reg > SLOTS) return SLOTS;
		return slot_count_reg;
	endfunction

	function automatic void place_timer(input bit [19:0] delay, output int slot,
			output bit [31:0] rnd);
		int n;
		int pos;
		n = wheel_size();
		pos = cur_slot + delay / (tick_ms_reg == 0 ? 1 : tick_ms_reg);
		slot = pos % n;
		rnd = rot_count + 32'(pos / n);
	endfunction

	function automatic void link_timer(int slot, int e);
		link_idx[e] = 5'(head_idx[slot]);
		link_ok[e] = head_ok[slot];
		head_idx[slot] = 8'(e);
		head_ok[slot] = 1'b1;
	endfunction

	function automatic result_t make_beat(logic [1:0] k, logic [15:0] id, int slot,
			logic lst);
		result_t r;
		r.kind = k;
		r.fired_id = id;
		r.slot_now = 8'(slot);
		r.last = lst;
		return r;
	endfunction

	function automatic void predict_wheel(in_item_t it);
		int slot;
		bit [31:0] rnd;
		int e;
		int prev;
		int walked;
		int cur;
		bit have;
		bit nv;
		int nx;
		int rearm_q[$];
		if (it.command == CMD_ADD) begin
			place_timer(it.first_delay_ms, slot, rnd);
			e = -1;
			for (int i = TIMERS - 1; i >= 0; i--)
				if (free_set[i]) e = i;
			if (e < 0) begin
				pending_q.push_back(make_beat(KIND_FULL, 16'd0, slot, 1'b1));
				return;
			end
			free_set[e] = 1'b0;
			ent_tag[e] = it.timer_id;
			ent_round[e] = rnd;
			ent_period[e] = it.period_ms;
			ent_repeat[e] = it.repeating;
			link_timer(slot, e);
			pending_q.push_back(make_beat(KIND_ADD_OK, 16'd0, slot, 1'b1));
			return;
		end
		cur = cur_slot % SLOTS;
		have = head_ok[cur];
		e = head_idx[cur] % TIMERS;
		prev = -1;
		walked = 0;
		while (have && walked < TIMERS) begin
			nv = link_ok[e];
			nx = link_idx[e];
			walked++;
			if (ent_round[e] == rot_count) begin
				pending_q.push_back(make_beat(KIND_FIRED, ent_tag[e], cur, 1'b0));
				if (prev >= 0) begin
					link_idx[prev] = 5'(nx);
					link_ok[prev] = nv;
				end else begin
					head_idx[cur] = 8'(nx);
					head_ok[cur] = nv;
				end
				if (ent_repeat[e]) rearm_q.push_back(e);
				else free_set[e] = 1'b1;
			end else begin
				prev = e;
			end
			have = nv;
			e = nx;
		end
		// re-arm newest fired first, before the slot advances
		while (rearm_q.size() > 0) begin
			e = rearm_q.pop_back();
			place_timer(ent_period[e], slot, rnd);
			ent_round[e] = rnd;
			link_timer(slot, e);
		end
		pending_q.push_back(make_beat(KIND_DONE, 16'd0, cur, 1'b1));
		cur_slot++;
		if (cur_slot >= wheel_size()) begin
			cur_slot = 0;
			rot_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %p", $time, result);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (result.kind !== want.kind || result.fired_id !== want.fired_id ||
						result.slot_now !== want.slot_now || result.last !== want.last) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic idle_burst();
		int n;
		if (no_gaps || $urandom_range(0, 3) != 0) return;
		n = $urandom_range(1, 18);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_item(in_item_t it);
		idle_burst();
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_wheel(it);
	endtask

	task automatic add_timer(logic [15:0] id, logic [19:0] delay, logic [19:0] period,
			logic rep);
		in_item_t it;
		it.command = CMD_ADD;
		it.timer_id = id;
		it.first_delay_ms = delay;
		it.period_ms = period;
		it.repeating = rep;
		send_item(it);
	endtask

	task automatic tick_wheel();
		in_item_t it;
		it = in_item_t'(58'({$urandom, $urandom}));
		it.command = CMD_TICK;
		send_item(it);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SLOT_COUNT) slot_count_reg = val[8:0];
		else tick_ms_reg = val;
	endtask

	task automatic test_directed();
		add_timer(16'h0000, 20'd0, 20'd0, 1'b0);
		add_timer(16'hffff, 20'hfffff, 20'hfffff, 1'b1);
		add_timer(16'h1234, 20'd10, 20'd20, 1'b1);
		add_timer(16'h00aa, 20'd9, 20'd0, 1'b0);
		add_timer(16'h5555, 20'd25, 20'd0, 1'b0);
		add_timer(16'haaaa, 20'd2560, 20'd0, 1'b0);
		repeat (8) tick_wheel();
	endtask

	// fill the pool, overflow it, then tick the wheel
	task automatic test_pool_full();
		write_reg(CFG_SLOT_COUNT, 10'd2);
		write_reg(CFG_TICK_MS, 10'd1);
		for (int i = 0; i < TIMERS + 2; i++)
			add_timer(16'(i + 16'h100), 20'($urandom_range(0, 3)), 20'd0, 1'b0);
		repeat (6) tick_wheel();
	endtask

	// out-of-range settings and a current slot left past a shrunken wheel
	task automatic test_reg_edges();
		write_reg(CFG_SLOT_COUNT, 10'd0);
		write_reg(CFG_TICK_MS, 10'd0);
		add_timer(16'h0bad, 20'd3, 20'd1, 1'b0);
		repeat (3) tick_wheel();
		write_reg(CFG_SLOT_COUNT, 10'h1ff);
		write_reg(CFG_TICK_MS, 10'd1023);
		repeat (5) tick_wheel();
		write_reg(CFG_SLOT_COUNT, 10'd3);
		add_timer(16'h0c0d, 20'd2046, 20'd0, 1'b0);
		repeat (3) tick_wheel();
	endtask

	task automatic test_random(int count);
		int span;
		logic [19:0] dly;
		logic [19:0] per;
		for (int i = 0; i < count; i++) begin
			span = wheel_size() * (tick_ms_reg == 0 ? 1 : tick_ms_reg);
			if ($urandom_range(0, 9) < 4) begin
				tick_wheel();
			end else begin
				dly = ($urandom_range(0, 15) == 0) ? 20'($urandom) : 20'($urandom_range(0, 2 * span));
				per = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(1, span));
				add_timer(16'($urandom), dly, per, $urandom_range(0, 11) == 0);
			end
		end
	endtask

	initial begin
		int slot_set [5] = '{1, 2, 5, 256, 300};
		int tick_set [5] = '{1, 1000, 3, 10, 512};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_SLOT_COUNT;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		no_gaps = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			head_idx[i] = '0;
			head_ok[i] = 1'b0;
		end
		free_set = '1;
		cur_slot = 0;
		rot_count = '0;
		slot_count_reg = SLOT_COUNT_RST;
		tick_ms_reg = TICK_MS_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		test_directed();
		test_pool_full();
		test_reg_edges();
		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_SLOT_COUNT, 10'(slot_set[p]));
			write_reg(CFG_TICK_MS, 10'(tick_set[p]));
			if (p == 4) no_gaps = 1'b1;
			test_random(p == 1 ? 43 : 40);
		end
		drain();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
